FILE: hdl/kscl_pkg.sv
// shared types, constants and helper functions for the keypad scanner and code lock
package kscl_pkg;

	localparam int ColW   = 4;
	localparam int RowW   = 4;
	localparam int CodeW  = 8;
	localparam int NumW   = 5;
	localparam int EntW   = 3;
	localparam int DigW   = 2;
	localparam int NumKeys = 4;
	localparam int CfgIdxW = 2;

	localparam logic [ColW-1:0] COLS_IDLE = 4'hF;
	localparam logic [RowW-1:0] ROW_NONE  = 4'hF;
	localparam logic [RowW-1:0] ROW_0     = 4'hE;
	localparam logic [RowW-1:0] ROW_1     = 4'hD;
	localparam logic [RowW-1:0] ROW_2     = 4'hB;
	localparam logic [RowW-1:0] ROW_3     = 4'h7;

	localparam logic [CfgIdxW-1:0] REG_CODE_KEY0 = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CODE_KEY1 = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CODE_KEY2 = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CODE_KEY3 = 2'd3;

	localparam logic [CodeW-1:0] CODE_KEY0_RST = 8'hBE;
	localparam logic [CodeW-1:0] CODE_KEY1_RST = 8'hD7;
	localparam logic [CodeW-1:0] CODE_KEY2_RST = 8'hDD;
	localparam logic [CodeW-1:0] CODE_KEY3_RST = 8'hDB;

	localparam logic [DigW-1:0] DIG_LAST = 2'd3;

	typedef struct packed {
		logic [RowW-1:0]  row_drive;
		logic             key_valid;
		logic [CodeW-1:0] key_code;
		logic [NumW-1:0]  key_number;
		logic [EntW-1:0]  digits_entered;
		logic             is_unlocked;
		logic             led_green;
		logic             led_red;
	} kscl_res_t;

	function automatic logic [2:0] low_bit_pos(input logic [3:0] nib);
		logic [2:0] pos;
		unique case (nib)
			4'hE:    pos = 3'd0;
			4'hD:    pos = 3'd1;
			4'hB:    pos = 3'd2;
			4'h7:    pos = 3'd3;
			default: pos = 3'd4;
		endcase
		return pos;
	endfunction

	function automatic logic [RowW-1:0] next_row(input logic [RowW-1:0] pat);
		logic [RowW-1:0] nx;
		unique case (pat)
			ROW_0:   nx = ROW_1;
			ROW_1:   nx = ROW_2;
			ROW_2:   nx = ROW_3;
			default: nx = ROW_0;
		endcase
		return nx;
	endfunction

	function automatic logic [NumW-1:0] key_num(input logic [CodeW-1:0] code);
		logic [2:0] r;
		logic [2:0] c;
		r = low_bit_pos(code[7:4]);
		c = low_bit_pos(code[3:0]);
		if (r[2] || c[2]) begin
			return '0;
		end
		return {1'b0, r[1:0], c[1:0]} + NumW'(1);
	endfunction

endpackage

FILE: hdl/kscl_if.sv
// valid/ready channel interfaces for scan ticks, results and register writes
interface kscl_scan_if import kscl_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ColW-1:0] column_sense;

	modport source (output valid, output column_sense, input ready);
	modport sink   (input valid, input column_sense, output ready);
endinterface

interface kscl_res_if import kscl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RowW-1:0]  row_drive;
	logic             key_valid;
	logic [CodeW-1:0] key_code;
	logic [NumW-1:0]  key_number;
	logic [EntW-1:0]  digits_entered;
	logic             is_unlocked;
	logic             led_green;
	logic             led_red;

	modport source (output valid, output row_drive, output key_valid, output key_code,
		output key_number, output digits_entered, output is_unlocked, output led_green,
		output led_red, input ready);
	modport sink   (input valid, input row_drive, input key_valid, input key_code,
		input key_number, input digits_entered, input is_unlocked, input led_green,
		input led_red, output ready);
endinterface

interface kscl_cfg_if import kscl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CodeW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/keypad_scan_code_lock_core.sv
// keypad scanner and four-key combination lock, top level
//
//  channel  role   word
//  scan     sink   column_sense, one scan tick
//  result   source row_drive, key fields, digit count, lock and led state
//  cfg      sink   index, data: write of one expected scan code
//
// one word per cycle; a tick enters the input register, then one pass of
// scan and compare logic fills the result register.
// the lock state advances as a tick moves into the result register.
// reset clears the state and loads the default code; cfg is always ready.
// a stalled result holds the result register and backs up into the input register.
module keypad_scan_code_lock_core import kscl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kscl_scan_if.sink  scan,
	kscl_res_if.source result,
	kscl_cfg_if.sink   cfg
);

	logic                  valid_s1;
	logic [ColW-1:0]       cols_s1;
	logic                  valid_s2;
	kscl_res_t             res_s2;
	logic                  advance;

	logic [CodeW-1:0]      code_q [NumKeys];
	logic                  wait_q;
	logic [RowW-1:0]       row_q;
	logic [DigW-1:0]       digit_q;
	logic                  match_q;
	logic                  unlocked_q;
	logic                  green_q;
	logic                  red_q;

	logic                  wait_d;
	logic [RowW-1:0]       row_d;
	logic [DigW-1:0]       digit_d;
	logic                  match_d;
	logic                  unlocked_d;
	logic                  green_d;
	logic                  red_d;
	kscl_res_t             res_d;

	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready  = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			cols_s1 <= scan.column_sense;
		end
	end

	always_comb begin
		logic             key;
		logic [CodeW-1:0] code;
		logic [EntW-1:0]  entered;
		logic             match_now;

		wait_d     = wait_q;
		row_d      = row_q;
		digit_d    = digit_q;
		match_d    = match_q;
		unlocked_d = unlocked_q;
		green_d    = green_q;
		red_d      = red_q;
		key        = 1'b0;
		code       = '0;

		if (wait_q) begin
			if (cols_s1 == COLS_IDLE) begin
				wait_d = 1'b0;
				row_d  = ROW_0;
			end
		end else if (cols_s1 != COLS_IDLE) begin
			key    = 1'b1;
			code   = {row_q, cols_s1};
			wait_d = 1'b1;
		end else begin
			row_d = next_row(row_q);
		end

		entered   = {1'b0, digit_q};
		match_now = match_q && (code == code_q[digit_q]);

		if (key) begin
			if (unlocked_q) begin
				unlocked_d = 1'b0;
				green_d    = 1'b0;
				red_d      = 1'b0;
				digit_d    = '0;
				match_d    = 1'b1;
				entered    = '0;
			end else begin
				if (digit_q == '0) begin
					green_d = 1'b0;
					red_d   = 1'b0;
				end
				entered = {1'b0, digit_q} + EntW'(1);
				if (digit_q == DIG_LAST) begin
					if (match_now) begin
						unlocked_d = 1'b1;
						green_d    = 1'b1;
					end else begin
						red_d = 1'b1;
					end
					digit_d = '0;
					match_d = 1'b1;
				end else begin
					digit_d = digit_q + DigW'(1);
					match_d = match_now;
				end
			end
		end

		res_d.row_drive      = row_d;
		res_d.key_valid      = key;
		res_d.key_code       = code;
		res_d.key_number     = key ? key_num(code) : '0;
		res_d.digits_entered = entered;
		res_d.is_unlocked    = unlocked_d;
		res_d.led_green      = green_d;
		res_d.led_red        = red_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q     <= 1'b1;
			row_q      <= ROW_NONE;
			digit_q    <= '0;
			match_q    <= 1'b1;
			unlocked_q <= 1'b0;
			green_q    <= 1'b0;
			red_q      <= 1'b0;
		end else if (advance) begin
			wait_q     <= wait_d;
			row_q      <= row_d;
			digit_q    <= digit_d;
			match_q    <= match_d;
			unlocked_q <= unlocked_d;
			green_q    <= green_d;
			red_q      <= red_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q[REG_CODE_KEY0] <= CODE_KEY0_RST;
			code_q[REG_CODE_KEY1] <= CODE_KEY1_RST;
			code_q[REG_CODE_KEY2] <= CODE_KEY2_RST;
			code_q[REG_CODE_KEY3] <= CODE_KEY3_RST;
		end else if (cfg.valid && cfg.ready) begin
			code_q[cfg.index] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid          = valid_s2;
	assign result.row_drive      = res_s2.row_drive;
	assign result.key_valid      = res_s2.key_valid;
	assign result.key_code       = res_s2.key_code;
	assign result.key_number     = res_s2.key_number;
	assign result.digits_entered = res_s2.digits_entered;
	assign result.is_unlocked    = res_s2.is_unlocked;
	assign result.led_green      = res_s2.led_green;
	assign result.led_red        = res_s2.led_red;

	// scanning always drives exactly one row
	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!wait_q |-> $onehot(~row_q))
		else $error("row pattern not a single low bit while scanning");

	// green tracks the unlocked state
	a_green_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.led_green == res_s2.is_unlocked))
		else $error("green led and unlock state disagree");

	a_leds_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.led_green && res_s2.led_red))
		else $error("both leds on");

	a_num_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.key_valid |-> (res_s2.key_number == '0 && res_s2.key_code == '0))
		else $error("key fields set without a key");

	// a word held in the input register is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cols_s1))
		else $error("input register lost a word");

endmodule
